// ===== rtl/hfd_pkg.sv =====
// Shared types and constants for the heartbeat failure detector.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package hfd_pkg;

    localparam int DEFAULT_MAX_NODES = 16;

    localparam int PEER_W      = 4;
    localparam int HB_W        = 64;
    localparam int BALLOT_W    = 32;
    localparam int SIZE_W      = 5;
    localparam int SILENCE_W   = 16;
    localparam int FAIL_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MOD_CNT_W   = $clog2(BALLOT_W);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_FAIL_LIMIT = 2'd2;

    localparam logic [SIZE_W-1:0]    RST_SYSTEM_SIZE     = 5'd3;
    localparam logic [SILENCE_W-1:0] RST_SILENCE_LIMIT   = 16'd15;
    localparam logic [FAIL_W-1:0]    RST_READ_FAIL_LIMIT = 8'd1;

    localparam logic [SIZE_W-1:0] MIN_GROUP = 5'd2;

    localparam logic FUNC_POLL   = 1'b0;
    localparam logic FUNC_BALLOT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the accepted request
        logic eval;       // apply the poll update
        logic mod_start;  // launch the modulo unit
        logic mod_succ;   // operand/destination: 1 successor, 0 leader
        logic mod_write;  // store the modulo result
        logic emit;       // load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic func;
        logic lead_fail;
        logic mod_done;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/hfd_mod.sv =====
// Iterative remainder unit: 32-bit dividend modulo a 5-bit divisor, one bit a cycle.
// Depends on hfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hfd_mod (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [hfd_pkg::BALLOT_W-1:0]  i_dividend,
    input  wire logic [hfd_pkg::SIZE_W-1:0]    i_divisor,
    output logic                               o_done,
    output logic [hfd_pkg::PEER_W-1:0]         o_rem
);
    import hfd_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [MOD_CNT_W-1:0]  r_cnt;
    logic [BALLOT_W-1:0]   r_dvd;
    logic [PEER_W-1:0]     r_rem;
    logic [SIZE_W-1:0]     w_trial;
    logic [PEER_W-1:0]     n_rem;

    // remainder stays below the divisor (at most 16), so it fits in four bits
    assign w_trial = {r_rem, r_dvd[BALLOT_W-1]};
    assign n_rem   = (w_trial >= i_divisor) ? PEER_W'(w_trial - i_divisor)
                                            : PEER_W'(w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MOD_CNT_W'(BALLOT_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[BALLOT_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== rtl/hfd_ctrl.sv =====
// Controller state machine: handshakes and sequencing of the datapath.
// Depends on hfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hfd_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire hfd_pkg::t_status i_status,
    output hfd_pkg::t_cmd         o_cmd
);
    import hfd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MSTART,
        S_MWAIT,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_sel, n_sel;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.mod_succ = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.func == FUNC_BALLOT) begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.mod_succ  = 1'b0;
                    n_sel           = 1'b0;
                    n_state         = S_MWAIT;
                end else begin
                    o_cmd.eval = 1'b1;
                    n_state    = i_status.lead_fail ? S_MSTART : S_EMIT;
                end
            end
            S_MSTART: begin
                o_cmd.mod_start = 1'b1;
                o_cmd.mod_succ  = 1'b1;
                n_sel           = 1'b1;
                n_state         = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_status.mod_done) begin
                    o_cmd.mod_write = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sel       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sel       <= n_sel;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hfd_dp.sv =====
// Datapath: configuration, per-peer state, poll update, leader registers,
// result register. Depends on hfd_pkg and hfd_mod.
`timescale 1ns / 1ps
`default_nettype none

module hfd_dp #(
    parameter int MAX_NODES = hfd_pkg::DEFAULT_MAX_NODES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [hfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [hfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_func,
    input  wire logic [hfd_pkg::PEER_W-1:0]      i_peer,
    input  wire logic                            i_read_ok,
    input  wire logic [hfd_pkg::HB_W-1:0]        i_heartbeat,
    input  wire logic [hfd_pkg::BALLOT_W-1:0]    i_ballot,
    input  wire hfd_pkg::t_cmd                   i_cmd,
    output hfd_pkg::t_status                     o_status,
    output logic [hfd_pkg::PEER_W-1:0]           o_peer_echo,
    output logic                                 o_newly_failed,
    output logic                                 o_already_failed,
    output logic                                 o_leader_failed,
    output logic [hfd_pkg::PEER_W-1:0]           o_next_leader,
    output logic                                 o_leader_stable
);
    import hfd_pkg::*;

    localparam int NODE_SLOTS = (MAX_NODES < 16) ? MAX_NODES : 16;
    localparam int IDX_W      = $clog2(NODE_SLOTS);
    localparam logic [SIZE_W-1:0] SLOTS_SZ = SIZE_W'(NODE_SLOTS);

    localparam logic [FAIL_W-1:0]    FAIL_SAT    = '1;
    localparam logic [SILENCE_W-1:0] SILENCE_SAT = '1;

    // configuration
    logic [SIZE_W-1:0]    r_system_size;
    logic [SILENCE_W-1:0] r_silence_limit;
    logic [FAIL_W-1:0]    r_read_fail_limit;

    // per-peer state
    logic [HB_W-1:0]      r_last  [NODE_SLOTS];
    logic [SILENCE_W-1:0] r_score [NODE_SLOTS];
    logic [FAIL_W-1:0]    r_fcnt  [NODE_SLOTS];
    logic [NODE_SLOTS-1:0] r_failed;

    logic [PEER_W-1:0] r_leader;
    logic [PEER_W-1:0] r_successor;
    logic              r_stable;

    // request held while it is worked on
    logic                r_func;
    logic [PEER_W-1:0]   r_peer;
    logic                r_read_ok;
    logic [HB_W-1:0]     r_hb;
    logic [BALLOT_W-1:0] r_ballot;

    logic r_newly, r_already, r_lead;

    // result register
    logic [PEER_W-1:0] r_o_peer;
    logic              r_o_newly, r_o_already, r_o_lead;
    logic [PEER_W-1:0] r_o_next;
    logic              r_o_stable;

    logic [SIZE_W-1:0]    w_group;
    logic                 w_in_range;
    logic [IDX_W-1:0]     w_idx;
    logic [HB_W-1:0]      w_last;
    logic [SILENCE_W-1:0] w_score;
    logic [FAIL_W-1:0]    w_fcnt;
    logic [FAIL_W-1:0]    n_fcnt;
    logic [SILENCE_W-1:0] n_score;
    logic                 w_already;
    logic                 w_fail_path;
    logic                 w_record_only;
    logic                 w_newly;
    logic                 w_lead;
    logic [BALLOT_W-1:0]  w_dividend;
    logic [SIZE_W-1:0]    w_peer_inc;
    logic                 w_mod_done;
    logic [PEER_W-1:0]    w_mod_rem;

    // clamp the group size to the valid range
    always_comb begin
        if (r_system_size < MIN_GROUP) begin
            w_group = MIN_GROUP;
        end else if (r_system_size > SLOTS_SZ) begin
            w_group = SLOTS_SZ;
        end else begin
            w_group = r_system_size;
        end
    end

    assign w_in_range = ({1'b0, r_peer} < SLOTS_SZ);
    assign w_idx      = r_peer[IDX_W-1:0];
    assign w_last     = r_last[w_idx];
    assign w_score    = r_score[w_idx];
    assign w_fcnt     = r_fcnt[w_idx];

    assign n_fcnt  = (w_fcnt == FAIL_SAT) ? w_fcnt : w_fcnt + 1'b1;
    assign n_score = (r_hb != w_last)     ? '0
                   : (w_score == SILENCE_SAT) ? w_score : w_score + 1'b1;

    assign w_already     = w_in_range && r_failed[w_idx];
    assign w_fail_path   = w_in_range && !w_already && !r_read_ok;
    assign w_record_only = w_in_range && !w_already && r_read_ok && (w_last == '0);

    always_comb begin
        w_newly = 1'b0;
        if (w_fail_path) begin
            w_newly = (n_fcnt > r_read_fail_limit);
        end else if (w_in_range && !w_already && r_read_ok && !w_record_only) begin
            w_newly = (n_score > r_silence_limit);
        end
    end

    assign w_lead = w_newly && (r_peer == r_leader);

    assign o_status.func      = r_func;
    assign o_status.lead_fail = w_lead;
    assign o_status.mod_done  = w_mod_done;

    assign w_peer_inc = SIZE_W'(r_peer) + 1'b1;
    assign w_dividend = i_cmd.mod_succ ? BALLOT_W'(w_peer_inc) : r_ballot;

    hfd_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_group),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_system_size     <= RST_SYSTEM_SIZE;
            r_silence_limit   <= RST_SILENCE_LIMIT;
            r_read_fail_limit <= RST_READ_FAIL_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYSTEM_SIZE:     r_system_size     <= i_cfg_data[SIZE_W-1:0];
                CFG_SILENCE_LIMIT:   r_silence_limit   <= i_cfg_data[SILENCE_W-1:0];
                CFG_READ_FAIL_LIMIT: r_read_fail_limit <= i_cfg_data[FAIL_W-1:0];
                default: ;
            endcase
        end
    end

    // per-peer state and leader registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NODE_SLOTS; k++) begin
                r_last[k]  <= '0;
                r_score[k] <= '0;
                r_fcnt[k]  <= '0;
            end
            r_failed    <= '0;
            r_leader    <= '0;
            r_successor <= '0;
            r_stable    <= 1'b1;
        end else begin
            if (i_cmd.eval && w_in_range && !w_already) begin
                if (!r_read_ok) begin
                    r_fcnt[w_idx] <= n_fcnt;
                end else if (w_record_only) begin
                    r_last[w_idx] <= r_hb;
                end else begin
                    r_score[w_idx] <= n_score;
                    r_last[w_idx]  <= r_hb;
                end
                if (w_newly) begin
                    r_failed[w_idx] <= 1'b1;
                end
                if (w_lead) begin
                    r_stable <= 1'b0;
                end
            end
            if (i_cmd.mod_write) begin
                if (i_cmd.mod_succ) begin
                    r_successor <= w_mod_rem;
                end else begin
                    r_leader <= w_mod_rem;
                end
            end
        end
    end

    // request capture and outcome flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_func;
            r_peer    <= i_peer;
            r_read_ok <= i_read_ok;
            r_hb      <= i_heartbeat;
            r_ballot  <= i_ballot;
            r_newly   <= 1'b0;
            r_already <= 1'b0;
            r_lead    <= 1'b0;
        end else if (i_cmd.eval) begin
            r_newly   <= w_newly;
            r_already <= w_already;
            r_lead    <= w_lead;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_peer    <= r_peer;
            r_o_newly   <= r_newly;
            r_o_already <= r_already;
            r_o_lead    <= r_lead;
            r_o_next    <= r_successor;
            r_o_stable  <= r_stable;
        end
    end

    assign o_peer_echo      = r_o_peer;
    assign o_newly_failed   = r_o_newly;
    assign o_already_failed = r_o_already;
    assign o_leader_failed  = r_o_lead;
    assign o_next_leader    = r_o_next;
    assign o_leader_stable  = r_o_stable;

endmodule

`default_nettype wire

// ===== rtl/heartbeat_failure_detector_core.sv =====
// Heartbeat failure detector: one request in flight, result held in an output register.
// A poll that fails no leader steps through S_EVAL to S_EMIT; a ballot request waits in
// S_MWAIT for the remainder unit, a poll that fails the leader passes S_MSTART and S_MWAIT;
// the remainder unit takes one dividend bit a cycle. A new request is taken only after the
// hand-off, which a stalled result can hold up; a request is taken while a result waits.
// Reset: synchronous, active low; clears all peer state and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module heartbeat_failure_detector_core #(
    parameter int MAX_NODES = hfd_pkg::DEFAULT_MAX_NODES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [hfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [hfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_func,
    input  wire logic [hfd_pkg::PEER_W-1:0]      i_peer,
    input  wire logic                            i_read_ok,
    input  wire logic [hfd_pkg::HB_W-1:0]        i_heartbeat,
    input  wire logic [hfd_pkg::BALLOT_W-1:0]    i_ballot,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [hfd_pkg::PEER_W-1:0]           o_peer_echo,
    output logic                                 o_newly_failed,
    output logic                                 o_already_failed,
    output logic                                 o_leader_failed,
    output logic [hfd_pkg::PEER_W-1:0]           o_next_leader,
    output logic                                 o_leader_stable
);
    import hfd_pkg::*;

    // Command and status between the sequencer and the datapath
    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer: takes a request only when idle, then steps through the
    // poll update (a ballot skips it), an optional remainder run, and the
    // hand-off to the result register (which may still be full and stalled).
    hfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Datapath: holds the configuration, the per-peer counters and last
    // heartbeat values, the leader/successor registers, and the shared
    // remainder unit used both for ballot mod size and (peer+1) mod size.
    hfd_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_func           (i_func),
        .i_peer           (i_peer),
        .i_read_ok        (i_read_ok),
        .i_heartbeat      (i_heartbeat),
        .i_ballot         (i_ballot),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_peer_echo      (o_peer_echo),
        .o_newly_failed   (o_newly_failed),
        .o_already_failed (o_already_failed),
        .o_leader_failed  (o_leader_failed),
        .o_next_leader    (o_next_leader),
        .o_leader_stable  (o_leader_stable)
    );

endmodule

`default_nettype wire

// ===== rtl/hfd_checker.sv =====
// Port-level checks on the heartbeat failure detector, bound to the top level.
// Depends on hfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hfd_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_stall,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic [hfd_pkg::PEER_W-1:0] o_peer_echo,
    input wire logic                       o_newly_failed,
    input wire logic                       o_already_failed,
    input wire logic                       o_leader_failed,
    input wire logic [hfd_pkg::PEER_W-1:0] o_next_leader,
    input wire logic                       o_leader_stable
);
    import hfd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_peer_echo)
            && $stable(o_newly_failed) && $stable(o_next_leader))
        else $error("stalled result changed");

    // one request at a time: stall rises right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while another is in flight");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_newly_failed && o_already_failed))
        else $error("peer both newly and already failed");

    a_lead_implies_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_leader_failed |-> o_newly_failed)
        else $error("leader failure without a new failure");

    a_lead_unstable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_leader_failed |-> !o_leader_stable)
        else $error("leader failure left the stable flag set");

endmodule

bind heartbeat_failure_detector_core hfd_checker u_hfd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_peer_echo      (o_peer_echo),
    .o_newly_failed   (o_newly_failed),
    .o_already_failed (o_already_failed),
    .o_leader_failed  (o_leader_failed),
    .o_next_leader    (o_next_leader),
    .o_leader_stable  (o_leader_stable)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for heartbeat_failure_detector_core: directed requests, then
// constrained-by-hand random traffic, checked against an in-bench model of the detector.
// Depends on rtl/hfd_pkg.sv and rtl/heartbeat_failure_detector_core.sv.
`timescale 1ns / 1ps

module tb;
    import hfd_pkg::*;

    localparam int NODE_SLOTS     = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_SETTLE     = 50;

    typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_RUNS} t_stall_mode;

    // one request as the block sees it
    typedef struct packed {
        logic                func;
        logic [PEER_W-1:0]   peer;
        logic                read_ok;
        logic [HB_W-1:0]     heartbeat;
        logic [BALLOT_W-1:0] ballot;
    } t_hb_req;

    // one result, field for field as on the output ports
    typedef struct packed {
        logic [PEER_W-1:0] peer_echo;
        logic              newly_failed;
        logic              already_failed;
        logic              leader_failed;
        logic [PEER_W-1:0] next_leader;
        logic              leader_stable;
    } t_hb_result;

    // ------------------------------------------------------------------
    // DUT signals: every input starts at a known value
    // ------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_func      = FUNC_POLL;
    logic [PEER_W-1:0]     i_peer      = '0;
    logic                  i_read_ok   = 1'b0;
    logic [HB_W-1:0]       i_heartbeat = '0;
    logic [BALLOT_W-1:0]   i_ballot    = '0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [PEER_W-1:0]     o_peer_echo;
    logic                  o_newly_failed;
    logic                  o_already_failed;
    logic                  o_leader_failed;
    logic [PEER_W-1:0]     o_next_leader;
    logic                  o_leader_stable;

    heartbeat_failure_detector_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_peer           (i_peer),
        .i_read_ok        (i_read_ok),
        .i_heartbeat      (i_heartbeat),
        .i_ballot         (i_ballot),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_peer_echo      (o_peer_echo),
        .o_newly_failed   (o_newly_failed),
        .o_already_failed (o_already_failed),
        .o_leader_failed  (o_leader_failed),
        .o_next_leader    (o_next_leader),
        .o_leader_stable  (o_leader_stable)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Detector model state and its copy of the configuration
    // ------------------------------------------------------------------
    logic [HB_W-1:0]      last_hb    [NODE_SLOTS];
    logic [SILENCE_W-1:0] silence    [NODE_SLOTS];
    logic [FAIL_W-1:0]    fail_cnt   [NODE_SLOTS];
    logic                 peer_dead  [NODE_SLOTS];
    logic [PEER_W-1:0]    leader_idx;
    logic [PEER_W-1:0]    successor;
    logic                 stable;
    logic                 failover_seen;   // internal only, never reaches a port
    logic [SIZE_W-1:0]    cfg_size;
    logic [SILENCE_W-1:0] cfg_silence;
    logic [FAIL_W-1:0]    cfg_fail;

    t_hb_result  expected_results [$];
    int          errors;
    int unsigned n_polls, n_ballots, n_ignored, n_declared, n_failovers, n_checked;

    // traffic shaping
    logic        gaps_on;
    t_stall_mode stall_mode;
    int unsigned burst_left;
    int unsigned stall_run;
    int          stuck_peer;     // peer whose heartbeat is frozen this phase, -1 for none
    int unsigned quiet_cycles;

    // Clamp the configured group to the range the detector works with.
    function automatic int unsigned group_size();
        int unsigned s;
        s = 32'(cfg_size);
        if (s < 2) s = 2;
        if (s > NODE_SLOTS) s = NODE_SLOTS;
        return s;
    endfunction

    // Mark a peer failed; hand leadership on when it held it.
    function automatic logic declare_failed(logic [PEER_W-1:0] p);
        peer_dead[p] = 1'b1;
        if (p == leader_idx) begin
            stable        = 1'b0;
            successor     = PEER_W'((int'(p) + 1) % group_size());
            failover_seen = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the model by one request and return the result it must produce.
    function automatic t_hb_result detector_update(t_hb_req r);
        t_hb_result res;
        res           = '0;
        res.peer_echo = r.peer;
        if (r.func == FUNC_BALLOT) begin
            leader_idx = PEER_W'(r.ballot % group_size());
        end else if (peer_dead[r.peer]) begin
            res.already_failed = 1'b1;
        end else if (!r.read_ok) begin
            if (fail_cnt[r.peer] != '1) fail_cnt[r.peer]++;
            if (fail_cnt[r.peer] > cfg_fail) begin
                res.newly_failed  = 1'b1;
                res.leader_failed = declare_failed(r.peer);
            end
        end else if (last_hb[r.peer] == '0) begin
            last_hb[r.peer] = r.heartbeat;
        end else begin
            if (r.heartbeat == last_hb[r.peer]) begin
                if (silence[r.peer] != '1) silence[r.peer]++;
            end else begin
                silence[r.peer] = '0;
            end
            last_hb[r.peer] = r.heartbeat;
            if (silence[r.peer] > cfg_silence) begin
                res.newly_failed  = 1'b1;
                res.leader_failed = declare_failed(r.peer);
            end
        end
        res.next_leader   = successor;
        res.leader_stable = stable;
        return res;
    endfunction

    function automatic int unsigned live_peers();
        int unsigned n;
        n = 0;
        for (int i = 0; i < NODE_SLOTS; i++) if (!peer_dead[i]) n++;
        return n;
    endfunction

    function automatic int pick_live_peer();
        int p;
        do p = $urandom_range(0, NODE_SLOTS - 1); while (peer_dead[p]);
        return p;
    endfunction

    function automatic t_hb_req poll_req(logic [PEER_W-1:0] p, logic ok, logic [HB_W-1:0] hb);
        t_hb_req r;
        r.func      = FUNC_POLL;
        r.peer      = p;
        r.read_ok   = ok;
        r.heartbeat = hb;
        r.ballot    = $urandom;    // ignored by a poll; keep it noisy
        return r;
    endfunction

    function automatic t_hb_req ballot_req(logic [BALLOT_W-1:0] b);
        t_hb_req r;
        r           = poll_req(PEER_W'($urandom_range(0, NODE_SLOTS - 1)),
                               1'($urandom_range(0, 1)), {$urandom, $urandom});
        r.func      = FUNC_BALLOT;
        r.ballot    = b;
        return r;
    endfunction

    // Random request. Only the stuck peer is pushed towards failure; every other peer
    // gets failed reads and frozen heartbeats only while they stay within the limits,
    // so the group does not run out of live peers before the run ends.
    function automatic t_hb_req next_random_request();
        t_hb_req     r;
        int unsigned pick;
        logic [PEER_W-1:0] p;
        r = poll_req(PEER_W'($urandom_range(0, NODE_SLOTS - 1)), 1'b1, {$urandom, $urandom});
        if ($urandom_range(0, 99) < 10) begin
            pick = $urandom_range(0, 9);
            if (stuck_peer >= 0 && pick < 3)
                r = ballot_req(stuck_peer + group_size() * $urandom_range(0, 1000));
            else if (pick < 5)
                r = ballot_req($urandom_range(0, 40));
            else
                r = ballot_req($urandom);
            return r;
        end
        pick = $urandom_range(0, 99);
        if (pick < 25) r.peer = leader_idx;
        else if (pick < 50 && stuck_peer >= 0) r.peer = PEER_W'(stuck_peer);
        p = r.peer;
        if (stuck_peer >= 0 && p == stuck_peer) begin
            if ($urandom_range(0, 1) == 1) r.read_ok = 1'b0;
            else if (last_hb[p] != '0) r.heartbeat = last_hb[p];
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 8 && fail_cnt[p] < cfg_fail)
                r.read_ok = 1'b0;
            else if (pick < 16 && last_hb[p] != '0 && silence[p] < cfg_silence)
                r.heartbeat = last_hb[p];
            else if (pick < 20)
                r.heartbeat = '0;
            else if (pick >= 30)
                r.heartbeat = last_hb[p] + $urandom_range(1, 1000);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Drive one request, hold it until taken, then predict its result. Outside a burst gap
    // it returns at the accepting edge with valid high: no toggle for the next request.
    task automatic send_request(input t_hb_req r, output logic ignored);
        t_hb_result want;
        i_in_valid  <= 1'b1;
        i_func      <= r.func;
        i_peer      <= r.peer;
        i_read_ok   <= r.read_ok;
        i_heartbeat <= r.heartbeat;
        i_ballot    <= r.ballot;
        do @(posedge i_clk); while (o_in_stall);
        want = detector_update(r);
        expected_results.push_back(want);
        ignored = want.already_failed;
        if (r.func == FUNC_BALLOT) n_ballots++;
        else n_polls++;
        if (want.already_failed) n_ignored++;
        if (want.newly_failed)   n_declared++;
        if (want.leader_failed)  n_failovers++;
        // close a burst with a random gap
        if (gaps_on) begin
            if (burst_left <= 1) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send(input t_hb_req r);
        logic ignored;
        send_request(r, ignored);
    endtask

    // Drop valid and hold until every predicted result has been taken.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write one register; the block must be idle.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SYSTEM_SIZE:     cfg_size    = data[SIZE_W-1:0];
            CFG_SILENCE_LIMIT:   cfg_silence = data[SILENCE_W-1:0];
            CFG_READ_FAIL_LIMIT: cfg_fail    = data[FAIL_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned size, input int unsigned sil,
                             input int unsigned rfl);
        wait_results_drained();
        write_cfg(CFG_SYSTEM_SIZE, CFG_DATA_W'(size));
        write_cfg(CFG_SILENCE_LIMIT, CFG_DATA_W'(sil));
        write_cfg(CFG_READ_FAIL_LIMIT, CFG_DATA_W'(rfl));
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern, checker, watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        case (stall_mode)
            STALL_NONE:   i_out_stall <= 1'b0;
            STALL_RANDOM: i_out_stall <= ($urandom_range(0, 2) == 0);
            default: begin
                // alternate stalled and open runs of random length
                if (stall_run == 0) begin
                    i_out_stall <= ~i_out_stall;
                    stall_run   <= $urandom_range(1, 24);
                end else begin
                    stall_run <= stall_run - 1;
                end
            end
        endcase
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    t_hb_result want_now;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing outstanding (peer_echo %0d)", o_peer_echo);
                errors++;
            end else begin
                want_now = expected_results.pop_front();
                check_field("peer_echo", 8'(want_now.peer_echo), 8'(o_peer_echo));
                check_field("newly_failed", 8'(want_now.newly_failed), 8'(o_newly_failed));
                check_field("already_failed", 8'(want_now.already_failed),
                            8'(o_already_failed));
                check_field("leader_failed", 8'(want_now.leader_failed), 8'(o_leader_failed));
                check_field("next_leader", 8'(want_now.next_leader), 8'(o_next_leader));
                check_field("leader_stable", 8'(want_now.leader_stable), 8'(o_leader_stable));
                n_checked++;
            end
        end
    end

    // Abort if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Register defaults: read-fail failover of the leader, ignored polls, ballot extremes,
    // heartbeat extremes including the zero that only records, a peer outside the group.
    task automatic test_reset_defaults();
        send(poll_req(4'd0, 1'b0, {$urandom, $urandom}));
        send(poll_req(4'd0, 1'b0, {$urandom, $urandom}));
        send(poll_req(4'd0, 1'b1, 64'd7));
        send(ballot_req(32'hFFFF_FFFF));
        send(ballot_req(32'd2));
        send(poll_req(4'd1, 1'b1, 64'd0));
        send(poll_req(4'd1, 1'b1, '1));
        send(poll_req(4'd1, 1'b1, '1));
        send(poll_req(4'd1, 1'b1, 64'h8000_0000_0000_0000));
        send(poll_req(4'd1, 1'b1, 64'd0));
        send(poll_req(4'd15, 1'b1, 64'd1));
        send(poll_req(4'd2, 1'b1, '1));
    endtask

    // Out-of-range group sizes clamp to two and sixteen; zero limits fail at once.
    task automatic test_group_size_clamp();
        configure(0, 0, 0);
        send(ballot_req(32'd5));
        send(poll_req(4'd1, 1'b0, {$urandom, $urandom}));
        configure(31, 0, 0);
        send(ballot_req(32'hFFFF_FFFF));
        send(poll_req(4'd15, 1'b1, 64'd5));
        send(poll_req(4'd15, 1'b1, 64'd5));
    endtask

    // The leader keeps the index computed when its ballot arrived; only the
    // successor sees the new size.
    task automatic test_size_change_after_ballot();
        configure(16, 0, 0);
        send(ballot_req(32'd6));
        configure(4, 0, 0);
        send(poll_req(4'd6, 1'b0, {$urandom, $urandom}));
    endtask

    // Highest limits: the read-fail count saturates and only then exceeds the limit.
    task automatic test_read_fail_saturation();
        configure(16, 65534, 254);
        gaps_on    = 1'b1;
        stall_mode = STALL_RUNS;
        send(ballot_req(32'd3));
        repeat (255) send(poll_req(4'd3, 1'b0, {$urandom, $urandom}));
        send(poll_req(4'd3, 1'b1, {$urandom, $urandom}));
    endtask

    // Random phase: one frozen peer at a time is driven to failure, up to max_kills.
    task automatic test_random_phase(input int unsigned n_items, input int unsigned max_kills);
        int unsigned done_items;
        int unsigned kills_left;
        t_hb_req     r;
        logic        ignored;
        done_items = 0;
        kills_left = max_kills;
        stuck_peer = (kills_left > 0 && live_peers() > 4) ? pick_live_peer() : -1;
        while (done_items < n_items) begin
            r = next_random_request();
            send_request(r, ignored);
            done_items++;
            if (stuck_peer >= 0 && peer_dead[stuck_peer]) begin
                kills_left--;
                stuck_peer = (kills_left > 0 && live_peers() > 4) ? pick_live_peer() : -1;
            end
            // now and then hold off until the block has emptied
            if ($urandom_range(0, 99) == 0) wait_results_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < NODE_SLOTS; i++) begin
            last_hb[i]   = '0;
            silence[i]   = '0;
            fail_cnt[i]  = '0;
            peer_dead[i] = 1'b0;
        end
        leader_idx    = '0;
        successor     = '0;
        stable        = 1'b1;
        failover_seen = 1'b0;
        cfg_size      = RST_SYSTEM_SIZE;
        cfg_silence   = RST_SILENCE_LIMIT;
        cfg_fail      = RST_READ_FAIL_LIMIT;
        errors        = 0;
        n_polls       = 0;
        n_ballots     = 0;
        n_ignored     = 0;
        n_declared    = 0;
        n_failovers   = 0;
        n_checked     = 0;
        gaps_on       = 1'b0;
        stall_mode    = STALL_RANDOM;
        burst_left    = 4;
        stall_run     = 0;
        stuck_peer    = -1;
        quiet_cycles  = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_group_size_clamp();
        test_size_change_after_ballot();
        test_read_fail_saturation();

        configure(5, 6, 3);
        gaps_on    = 1'b1;
        stall_mode = STALL_RANDOM;
        test_random_phase(250, 3);

        // back-to-back stretch: no burst gaps and no output stalls
        configure(16, 2, 0);
        gaps_on    = 1'b0;
        stall_mode = STALL_NONE;
        test_random_phase(250, 2);

        configure(2, 0, 8);
        gaps_on    = 1'b1;
        stall_mode = STALL_RUNS;
        test_random_phase(250, 2);

        wait_results_drained();
        repeat (END_SETTLE) @(posedge i_clk);

        $display("Covered %0d polls (%0d ignored as already failed) and %0d ballots;",
                 n_polls, n_ignored, n_ballots);
        $display("%0d peers declared failed, %0d leader failovers, %0d results checked, %0d errors",
                 n_declared, n_failovers, n_checked, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
